[rtl/core/landing_descent_rate_command_top_defines.svh]
// ---------------------------------------------------------------------------
// landing_descent_rate_command_top_defines
// Assertion macros for the descent-rate command block.
// ---------------------------------------------------------------------------
`ifndef LANDING_DESCENT_RATE_COMMAND_TOP_DEFINES_SVH
`define LANDING_DESCENT_RATE_COMMAND_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LDRC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LDRC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define LDRC_ASSERT_IMPL(label, clk, rst_n, prop)
`define LDRC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/core/ldrc_pkg.sv]
// ---------------------------------------------------------------------------
// ldrc_pkg
// Shared types and constants for the descent-rate command block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ldrc_pkg;
    localparam int unsigned SqW    = 32;
    localparam int unsigned RootW  = 16;
    localparam int unsigned NumW   = 31;
    localparam int unsigned SpdW   = 13;
    localparam int unsigned RadW   = 16;

    localparam logic [1:0] ST_LAND    = 2'd0;
    localparam logic [1:0] ST_HOLD    = 2'd1;
    localparam logic [1:0] ST_SCALED  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [2:0] REG_LZH  = 3'd0;
    localparam logic [2:0] REG_FDS  = 3'd1;
    localparam logic [2:0] REG_GR   = 3'd2;
    localparam logic [2:0] REG_VMIN = 3'd3;
    localparam logic [2:0] REG_VMAX = 3'd4;

    typedef struct packed {
        logic                    valid;
        logic                    direct;
        logic [1:0]              status;
        logic [SpdW-1:0]         vz;
        logic [RadW-1:0]         radius;
        logic signed [SpdW:0]    diff;
        logic [SpdW-1:0]         vmin;
    } t_ctl;

    typedef struct packed {
        logic [SqW-1:0]   rem;
        logic [RootW-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [NumW-1:0]  rem;
        logic [NumW-1:0]  quo;
        logic             neg;
    } t_div;
endpackage

[rtl/core/ldrc_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// ldrc_sqrt_cell
// One restoring square-root step, registered, with sideband carried along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ldrc_sqrt_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ldrc_pkg::t_ctl   i_ctl,
    input  ldrc_pkg::t_sqrt  i_sq,
    output ldrc_pkg::t_ctl   o_ctl,
    output ldrc_pkg::t_sqrt  o_sq
);
    import ldrc_pkg::*;

    localparam int unsigned Sh = 2 * (RootW - 1 - STEP);

    logic [SqW+1:0]  w_rem2;
    logic [SqW+1:0]  w_trial;
    logic [RootW-1:0] w_bit;
    t_ctl  r_ctl;
    t_sqrt r_sq;

    assign w_bit   = RootW'(1) << (RootW - 1 - STEP);
    assign w_rem2  = {2'b00, i_sq.rem};
    assign w_trial = ((SqW+2)'(i_sq.root) << (RootW - STEP))
                   + ((SqW+2)'(1) << Sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.direct <= i_ctl.direct;
        r_ctl.status <= i_ctl.status;
        r_ctl.vz     <= i_ctl.vz;
        r_ctl.radius <= i_ctl.radius;
        r_ctl.diff   <= i_ctl.diff;
        r_ctl.vmin   <= i_ctl.vmin;
        if (w_rem2 >= w_trial) begin
            r_sq.rem  <= SqW'(w_rem2 - w_trial);
            r_sq.root <= i_sq.root | w_bit;
        end else begin
            r_sq.rem  <= i_sq.rem;
            r_sq.root <= i_sq.root;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sq  = r_sq;
endmodule

[rtl/core/ldrc_div_cell.sv]
// ---------------------------------------------------------------------------
// ldrc_div_cell
// One restoring division step on a magnitude, registered, sideband along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ldrc_div_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ldrc_pkg::t_ctl  i_ctl,
    input  ldrc_pkg::t_div  i_dv,
    output ldrc_pkg::t_ctl  o_ctl,
    output ldrc_pkg::t_div  o_dv
);
    import ldrc_pkg::*;

    localparam int unsigned Bit = NumW - 1 - STEP;

    logic [NumW+RadW-1:0] w_rem;
    logic [NumW+RadW-1:0] w_sub;
    t_ctl r_ctl;
    t_div r_dv;

    assign w_rem = {{RadW{1'b0}}, i_dv.rem} >> Bit;
    assign w_sub = {{NumW{1'b0}}, i_ctl.radius};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.direct <= i_ctl.direct;
        r_ctl.status <= i_ctl.status;
        r_ctl.vz     <= i_ctl.vz;
        r_ctl.radius <= i_ctl.radius;
        r_ctl.diff   <= i_ctl.diff;
        r_ctl.vmin   <= i_ctl.vmin;
        r_dv.neg     <= i_dv.neg;
        if (w_rem >= w_sub) begin
            r_dv.rem <= i_dv.rem - NumW'(w_sub << Bit);
            r_dv.quo <= i_dv.quo | (NumW'(1) << Bit);
        end else begin
            r_dv.rem <= i_dv.rem;
            r_dv.quo <= i_dv.quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_dv  = r_dv;
endmodule

[rtl/core/landing_descent_rate_command_top.sv]
// ---------------------------------------------------------------------------
// landing_descent_rate_command_top
// Descent speed command from lateral offset and altitude.
// ---------------------------------------------------------------------------
// Usage: assert start with offset_x, offset_y and altitude while busy is
// low; busy is tied low, so one sample transfers every cycle. Each sample
// gives exactly one result on o_vz_command / o_status, marked by o_done for
// one cycle, in input order. o_done rises once the sample has passed
// through 51 register stages: one input register, a squaring stage, 16
// square-root cells, a gate/multiply stage, 31 division cells and one output
// stage. Throughput is one sample per cycle. Configuration transfers on the
// cfg channel (i_cfg_valid/o_cfg_ready, always ready); the user must do so
// only while no sample is in flight, which the block does not enforce.
// Reset clears the configuration registers to zero and empties the row. The
// receiver cannot stall; results are shown once and then dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "landing_descent_rate_command_top_defines.svh"
module landing_descent_rate_command_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic signed [16:0] i_altitude,
    output logic               o_done,
    output logic [12:0]        o_vz_command,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ldrc_pkg::*;

    logic [15:0]        r_lzh;
    logic signed [13:0] r_fds;
    logic [15:0]        r_gr;
    logic [12:0]        r_vmin;
    logic [12:0]        r_vmax;

    logic               r_v0;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [16:0] r_alt;

    t_ctl  r_c1;
    t_sqrt r_s1;
    logic signed [31:0] w_xx;
    logic signed [31:0] w_yy;

    t_ctl  w_sc [0:RootW];
    t_sqrt w_ss [0:RootW];

    t_ctl  r_c2;
    t_div  r_d2;
    t_ctl  w_dc [0:NumW];
    t_div  w_dd [0:NumW];

    logic               r_done;
    logic [12:0]        r_vz;
    logic [1:0]         r_st;

    logic [14:0] w_fmag;
    logic [12:0] w_fsat;
    logic signed [SpdW+RadW+1:0] w_num;
    logic [RadW-1:0]  w_err;
    logic signed [SpdW+1:0] w_q;
    logic signed [SpdW+1:0] w_v;
    logic w_hold_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lzh  <= '0;
            r_fds  <= '0;
            r_gr   <= '0;
            r_vmin <= '0;
            r_vmax <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LZH:  r_lzh  <= i_cfg_data;
                REG_FDS:  r_fds  <= i_cfg_data[13:0];
                REG_GR:   r_gr   <= i_cfg_data;
                REG_VMIN: r_vmin <= i_cfg_data[12:0];
                REG_VMAX: r_vmax <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign w_fmag = r_fds[13] ? 15'(-$signed({r_fds[13], r_fds})) : 15'(r_fds);
    assign w_fsat = (w_fmag > 15'd8191) ? 13'd8191 : w_fmag[12:0];

    assign w_xx = r_x * r_x;
    assign w_yy = r_y * r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_c1.valid <= 1'b0;
        end else begin
            r_v0       <= start;
            r_c1.valid <= r_v0;
        end
        r_x   <= i_offset_x;
        r_y   <= i_offset_y;
        r_alt <= i_altitude;
        r_s1.rem  <= $unsigned(w_xx) + $unsigned(w_yy);
        r_s1.root <= '0;
        r_c1.radius <= r_gr;
        r_c1.diff   <= $signed({1'b0, r_vmax}) - $signed({1'b0, r_vmin});
        r_c1.vmin   <= r_vmin;
        priority if (r_alt[16]) begin
            r_c1.direct <= 1'b1;
            r_c1.status <= ST_INVALID;
            r_c1.vz     <= '0;
        end else if ({1'b0, r_alt[15:0]} < {1'b0, r_lzh}) begin
            r_c1.direct <= 1'b1;
            r_c1.status <= ST_LAND;
            r_c1.vz     <= w_fsat;
        end else begin
            r_c1.direct <= 1'b0;
            r_c1.status <= ST_SCALED;
            r_c1.vz     <= '0;
        end
    end

    assign w_sc[0] = r_c1;
    assign w_ss[0] = r_s1;

    for (genvar g = 0; g < RootW; g++) begin : g_sqrt
        ldrc_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_sc[g]),
            .i_sq   (w_ss[g]),
            .o_ctl  (w_sc[g+1]),
            .o_sq   (w_ss[g+1])
        );
    end

    assign w_err = w_ss[RootW].root;
    assign w_num = w_sc[RootW].diff * $signed({1'b0, w_sc[RootW].radius - w_err});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.valid <= 1'b0;
        end else begin
            r_c2.valid <= w_sc[RootW].valid;
        end
        r_c2.radius <= w_sc[RootW].radius;
        r_c2.diff   <= w_sc[RootW].diff;
        r_c2.vmin   <= w_sc[RootW].vmin;
        if (!w_sc[RootW].direct && (w_err >= w_sc[RootW].radius)) begin
            r_c2.direct <= 1'b1;
            r_c2.status <= ST_HOLD;
            r_c2.vz     <= '0;
        end else begin
            r_c2.direct <= w_sc[RootW].direct;
            r_c2.status <= w_sc[RootW].status;
            r_c2.vz     <= w_sc[RootW].vz;
        end
        r_d2.neg <= w_num[SpdW+RadW+1];
        r_d2.rem <= w_num[SpdW+RadW+1] ? NumW'(-w_num) : NumW'(w_num);
        r_d2.quo <= '0;
    end

    assign w_dc[0] = r_c2;
    assign w_dd[0] = r_d2;

    for (genvar g = 0; g < NumW; g++) begin : g_div
        ldrc_div_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_dc[g]),
            .i_dv   (w_dd[g]),
            .o_ctl  (w_dc[g+1]),
            .o_dv   (w_dd[g+1])
        );
    end

    assign w_q = w_dd[NumW].neg ? -$signed((SpdW+2)'(w_dd[NumW].quo))
                                :  $signed((SpdW+2)'(w_dd[NumW].quo));
    assign w_v = $signed({2'b00, w_dc[NumW].vmin}) + w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dc[NumW].valid;
        end
        r_st <= w_dc[NumW].status;
        if (w_dc[NumW].direct) begin
            r_vz <= w_dc[NumW].vz;
        end else if (w_v < 0) begin
            r_vz <= '0;
        end else if (w_v > $signed(15'd8191)) begin
            r_vz <= 13'd8191;
        end else begin
            r_vz <= w_v[12:0];
        end
    end

    assign o_done       = r_done;
    assign o_vz_command = r_vz;
    assign o_status     = r_st;

    assign w_hold_out = w_dc[NumW].valid && (w_dc[NumW].status == ST_HOLD);

    `LDRC_ASSERT_IMPL(a_busy_low, i_clk, i_rst_n, busy == 1'b0)
    `LDRC_ASSERT_NEXT(a_start_flows, i_clk, i_rst_n, start, r_v0)
    `LDRC_ASSERT_NEXT(a_hold_zero, i_clk, i_rst_n, w_hold_out, o_vz_command == 13'd0)
endmodule
